>>> rtl/bpsr_pkg.sv
// ----------------------------------------------------------------------------
// bpsr_pkg
// Shared types and constants of the BMP pixel stream to RGB565 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bpsr_pkg;

  localparam int unsigned DimW    = 11;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  typedef enum logic [1:0] {
    FMT_NONE   = 2'd0,
    FMT_BGR888 = 2'd1,
    FMT_RGB555 = 2'd2,
    FMT_RGB565 = 2'd3
  } pix_fmt_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH   = 4'd0,
    REG_IMAGE_HEIGHT  = 4'd1,
    REG_PIXEL_FORMAT  = 4'd2,
    REG_ORIGIN_X      = 4'd3,
    REG_ORIGIN_Y      = 4'd4,
    REG_CENTER        = 4'd5,
    REG_WINDOW_WIDTH  = 4'd6,
    REG_WINDOW_HEIGHT = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DimW-1:0]   image_width;
    logic [DimW-1:0]   image_height;
    pix_fmt_e          pixel_format;
    logic [CoordW-1:0] origin_x;
    logic [CoordW-1:0] origin_y;
    logic              center_on_screen;
    logic [CoordW-1:0] window_width;
    logic [CoordW-1:0] window_height;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [CoordW-1:0] pixel_x;
    logic [CoordW-1:0] pixel_y;
    logic [ColorW-1:0] color565;
    logic              last_pixel;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/bpsr_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpsr_cfg_regs
// Configuration register file, written through an index and data channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsr_cfg_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [bpsr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [bpsr_pkg::CfgDatW-1:0] cfg_data_i,
  output bpsr_pkg::cfg_t                    cfg_o
);

  bpsr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (bpsr_pkg::cfg_idx_e'(cfg_index_i))
        bpsr_pkg::REG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_data_i[bpsr_pkg::DimW-1:0];
        bpsr_pkg::REG_IMAGE_HEIGHT:  cfg_d.image_height  = cfg_data_i[bpsr_pkg::DimW-1:0];
        bpsr_pkg::REG_PIXEL_FORMAT:  cfg_d.pixel_format  = bpsr_pkg::pix_fmt_e'(cfg_data_i[1:0]);
        bpsr_pkg::REG_ORIGIN_X:      cfg_d.origin_x      = cfg_data_i;
        bpsr_pkg::REG_ORIGIN_Y:      cfg_d.origin_y      = cfg_data_i;
        bpsr_pkg::REG_CENTER:        cfg_d.center_on_screen = cfg_data_i[0];
        bpsr_pkg::REG_WINDOW_WIDTH:  cfg_d.window_width  = cfg_data_i;
        bpsr_pkg::REG_WINDOW_HEIGHT: cfg_d.window_height = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_width:      bpsr_pkg::DimW'(1),
                 image_height:     bpsr_pkg::DimW'(1),
                 pixel_format:     bpsr_pkg::FMT_NONE,
                 origin_x:         '0,
                 origin_y:         '0,
                 center_on_screen: 1'b0,
                 window_width:     '0,
                 window_height:    '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpsr_in_stage.sv
// ----------------------------------------------------------------------------
// bpsr_in_stage
// Input register for one byte word and its frame start flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_start_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o,
  output logic            start_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       load;

  // The held word leaves in the same cycle that a new one may arrive.
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= in_byte_i;
      start_q <= in_start_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign start_o = start_q;

endmodule

`default_nettype wire

>>> rtl/bpsr_decoder.sv
// ----------------------------------------------------------------------------
// bpsr_decoder
// Byte sequencing, padding skip, colour conversion and screen position.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsr_decoder #(
  parameter int unsigned MAX_DIMENSION = 1024,
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       start_i,
  input  wire bpsr_pkg::cfg_t cfg_i,
  output bpsr_pkg::res_t  res_o
);

  localparam int unsigned DimW   = bpsr_pkg::DimW;
  localparam int unsigned CoordW = bpsr_pkg::CoordW;

  logic [1:0]      phase_q, phase_d;
  logic [15:0]     held_q, held_d;
  logic [DimW-1:0] col_q, col_d;
  logic [DimW-1:0] rows_q, rows_d;
  logic [1:0]      pad_q, pad_d;
  logic            done_q, done_d;

  logic [1:0]      ph;
  logic [15:0]     held;
  logic [DimW-1:0] col;
  logic [DimW-1:0] rows;
  logic [1:0]      pad;
  logic            done;

  logic            drawable;
  logic [2:0]      bpp;
  logic [2:0]      ph_next;
  logic [DimW-1:0] rows_dec;
  logic [1:0]      row_pad;
  logic [15:0]     word;
  logic [15:0]     color;
  logic signed [CoordW:0] dx, dy, hx, hy;
  logic [CoordW-1:0] ox, oy;

  assign drawable = (cfg_i.pixel_format != bpsr_pkg::FMT_NONE) &&
                    (cfg_i.image_width != '0) && (cfg_i.image_height != '0) &&
                    (32'(cfg_i.image_width) <= MAX_DIMENSION) &&
                    (32'(cfg_i.image_height) <= MAX_DIMENSION) &&
                    (CoordW'(cfg_i.image_width) <= cfg_i.window_width) &&
                    (CoordW'(cfg_i.image_height) <= cfg_i.window_height);

  // Centring halves a signed difference, rounding toward zero.
  assign dx = (CoordW+1)'(SCREEN_WIDTH) - (CoordW+1)'(cfg_i.image_width);
  assign dy = (CoordW+1)'(SCREEN_HEIGHT) - (CoordW+1)'(cfg_i.image_height);
  assign hx = (dx + (CoordW+1)'(dx[CoordW])) >>> 1;
  assign hy = (dy + (CoordW+1)'(dy[CoordW])) >>> 1;
  assign ox = cfg_i.center_on_screen ? hx[CoordW-1:0] : cfg_i.origin_x;
  assign oy = cfg_i.center_on_screen ? hy[CoordW-1:0] : cfg_i.origin_y;

  assign bpp = (cfg_i.pixel_format == bpsr_pkg::FMT_BGR888) ? 3'd3 : 3'd2;
  // Row length in bytes modulo four decides how much padding follows.
  assign row_pad = (cfg_i.pixel_format == bpsr_pkg::FMT_BGR888) ?
                   cfg_i.image_width[1:0] : {cfg_i.image_width[0], 1'b0};

  always_comb begin
    ph   = phase_q;
    held = held_q;
    col  = col_q;
    rows = rows_q;
    pad  = pad_q;
    done = done_q;
    if (start_i) begin
      ph   = '0;
      held = '0;
      col  = '0;
      pad  = '0;
      rows = cfg_i.image_height;
      done = !drawable;
    end
  end

  assign ph_next  = {1'b0, ph} + 3'd1;
  assign rows_dec = (rows != '0) ? rows - DimW'(1) : '0;
  assign word     = {byte_i, held[7:0]};

  always_comb begin
    case (cfg_i.pixel_format)
      bpsr_pkg::FMT_BGR888: color = {byte_i[7:3], held[15:10], held[7:3]};
      bpsr_pkg::FMT_RGB555: color = {word[14:5], 1'b0, word[4:0]};
      default:              color = word;
    endcase
  end

  always_comb begin
    phase_d = ph;
    held_d  = held;
    col_d   = col;
    rows_d  = rows;
    pad_d   = pad;
    done_d  = done;

    res_o            = '0;
    res_o.pixel_x    = ox + CoordW'(col);
    res_o.pixel_y    = oy + CoordW'(rows_dec);
    res_o.color565   = color;

    if (!done && (cfg_i.pixel_format != bpsr_pkg::FMT_NONE)) begin
      if (pad != '0) begin
        pad_d = pad - 2'd1;
        if (pad == 2'd1) begin
          rows_d = rows_dec;
          if (rows_dec == '0) begin
            done_d = 1'b1;
          end
        end
      end else if (ph_next < bpp) begin
        held_d  = (ph == 2'd0) ? {8'h00, byte_i} : word;
        phase_d = ph_next[1:0];
      end else begin
        res_o.valid = 1'b1;
        phase_d     = '0;
        held_d      = '0;
        if (({1'b0, col} + (DimW+1)'(1)) >= {1'b0, cfg_i.image_width}) begin
          col_d = '0;
          if (rows <= DimW'(1)) begin
            rows_d           = '0;
            done_d           = 1'b1;
            res_o.last_pixel = 1'b1;
          end else if (row_pad != '0) begin
            pad_d = row_pad;
          end else begin
            rows_d = rows - DimW'(1);
          end
        end else begin
          col_d = col + DimW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      held_q  <= '0;
      col_q   <= '0;
      rows_q  <= '0;
      pad_q   <= '0;
      done_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      col_q   <= col_d;
      rows_q  <= rows_d;
      pad_q   <= pad_d;
      done_q  <= done_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("byte phase reached an unused value");

  a_pad_at_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q != '0) |-> (col_q == '0 && phase_q == '0))
    else $error("padding skipped in the middle of a row");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.valid && res_o.last_pixel) |=> done_q)
    else $error("image not closed after its last pixel");

endmodule

`default_nettype wire

>>> rtl/bpsr_out_reg.sv
// ----------------------------------------------------------------------------
// bpsr_out_reg
// Result register that holds one pixel word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bpsr_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire bpsr_pkg::res_t res_i,
  input  wire logic           out_ready_i,
  output logic                free_o,
  output logic                out_valid_o,
  output logic [bpsr_pkg::CoordW-1:0] pixel_x_o,
  output logic [bpsr_pkg::CoordW-1:0] pixel_y_o,
  output logic [bpsr_pkg::ColorW-1:0] color565_o,
  output logic                last_pixel_o
);

  logic           valid_q, valid_d;
  bpsr_pkg::res_t res_q;
  logic           take;

  assign free_o = !valid_q || out_ready_i;
  assign take   = load_i && res_i.valid;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign pixel_x_o    = res_q.pixel_x;
  assign pixel_y_o    = res_q.pixel_y;
  assign color565_o   = res_q.color565;
  assign last_pixel_o = res_q.last_pixel;

endmodule

`default_nettype wire

>>> rtl/bmp_pixel_stream_to_rgb565_unit.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_to_rgb565_unit
// Converts uncompressed BMP pixel bytes into a stream of RGB565 screen pixels.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one pixel-data byte per word; tuser set marks
//   the first byte of an image and restarts the row and column counters.
//   Header values (size, format, origin, window) are written beforehand on
//   the configuration channel, which is always ready.
//   The master stream carries one pixel per word with its screen position;
//   tlast marks the final pixel of the image. Padding bytes, bytes after the
//   last pixel and bytes of an image that cannot be drawn produce nothing.
// Throughput and datapath:
//   One byte is taken every cycle while the receiver does not stall. A
//   byte is held in the input register and then decoded into the result
//   register, where the pixel word is valid once its last byte is decoded.
//   The rate is set by the single decode step between those two registers.
// Reset and stall:
//   Reset empties both registers and leaves the decoder idle until the next
//   frame start. When the receiver stalls, the result register holds its
//   word and the input register fills; tready then drops until space frees.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_stream_to_rgb565_unit #(
  parameter int unsigned MAX_DIMENSION = 1024,
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] frame_start
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,   // [15:0] pixel_x, [31:16] pixel_y,
                                             // [47:32] color565
  output logic             m_axis_tlast_o,   // last_pixel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [bpsr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [bpsr_pkg::CfgDatW-1:0] cfg_data_i
);

  bpsr_pkg::cfg_t cfg;
  bpsr_pkg::res_t res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_start;
  logic       out_free;
  logic       advance;

  assign advance = in_valid && out_free;

  bpsr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bpsr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_start_i (s_axis_tuser_i),
    .advance_i  (advance),
    .valid_o    (in_valid),
    .byte_o     (in_byte),
    .start_o    (in_start)
  );

  bpsr_decoder #(
    .MAX_DIMENSION (MAX_DIMENSION),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (in_byte),
    .start_i (in_start),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  bpsr_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance),
    .res_i        (res),
    .out_ready_i  (m_axis_tready_i),
    .free_o       (out_free),
    .out_valid_o  (m_axis_tvalid_o),
    .pixel_x_o    (m_axis_tdata_o[15:0]),
    .pixel_y_o    (m_axis_tdata_o[31:16]),
    .color565_o   (m_axis_tdata_o[47:32]),
    .last_pixel_o (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> tb/bmp_pixel_stream_to_rgb565_unit_test.sv
// ----------------------------------------------------------------------------
// bmp_pixel_stream_to_rgb565_unit_test
// Self-checking bench for the BMP pixel stream to RGB565 unit. A short list
// of hand-checked bytes comes first, then randomly sized images in all pixel
// formats, with padding, centering, window rejects and stray bytes. Each output
// word is checked against a hand value or a behavioral decoder in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_stream_to_rgb565_unit_test;

  localparam int MaxDim       = 1024;
  localparam int ScreenW      = 320;
  localparam int ScreenH      = 240;
  localparam int DecodeTarget = 850;
  localparam int QuietAfter   = 720;
  localparam int HoldCycles   = 60;
  localparam int SettleCycles = 8;
  localparam bpsr_pkg::cfg_idx_e RegUnused = bpsr_pkg::cfg_idx_e'(4'hF);

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  typedef struct {
    int         sel;
    logic [7:0] data;
    logic       fs;
    bit         typed;
    bit         has_px;
    pixel_t     px;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [47:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  bpsr_pkg::cfg_idx_e  cfg_index_i;
  logic [15:0]         cfg_data_i;

  bmp_pixel_stream_to_rgb565_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Decoder state mirrored by the bench.
  bpsr_pkg::cfg_t live_cfg;
  logic [1:0]  dec_phase = '0;
  logic [15:0] dec_held  = '0;
  logic [10:0] dec_col   = '0;
  logic [10:0] dec_rows  = '0;
  logic [1:0]  dec_pad   = '0;
  bit          dec_done  = 1'b1;

  pixel_t         expected_pixels[$];
  stim_row_t      dir_rows[$];
  bpsr_pkg::cfg_t dir_cfg[4];

  int  mismatches    = 0;
  int  pixels_seen   = 0;
  int  decoded_bytes = 0;
  int  bytes_sent    = 0;
  int  settings_used = 0;
  int  frames_sent   = 0;
  bit  quiet         = 1'b0;
  bit  hold_req      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    mismatches++;
    $display("mismatch at word %0d: %s got %h expected %h", pixels_seen, what, got, want);
  endtask

  function automatic bit fits(input bpsr_pkg::cfg_t c);
    return c.pixel_format != bpsr_pkg::FMT_NONE && c.image_width != 0 &&
           c.image_height != 0 &&
           int'(c.image_width) <= MaxDim && int'(c.image_height) <= MaxDim &&
           16'(c.image_width) <= c.window_width && 16'(c.image_height) <= c.window_height;
  endfunction

  function automatic void close_row();
    if (dec_rows > 0) dec_rows = dec_rows - 1'b1;
    if (dec_rows == 0) dec_done = 1'b1;
  endfunction

  // Advances the decoder by one byte; returns 1 when a pixel completes.
  function automatic bit decode_byte(input logic [7:0] b, input logic fs, output pixel_t px);
    int          bpp;
    int          pad;
    logic [15:0] v;
    logic [15:0] ox;
    logic [15:0] oy;
    px = '0;
    if (fs) begin
      dec_phase = '0;
      dec_held  = '0;
      dec_col   = '0;
      dec_pad   = '0;
      dec_rows  = live_cfg.image_height;
      dec_done  = !fits(live_cfg);
    end
    if (dec_done || live_cfg.pixel_format == bpsr_pkg::FMT_NONE) return 1'b0;
    decoded_bytes++;
    if (dec_pad != 0) begin
      dec_pad = dec_pad - 1'b1;
      if (dec_pad == 0) close_row();
      return 1'b0;
    end
    bpp = (live_cfg.pixel_format == bpsr_pkg::FMT_BGR888) ? 3 : 2;
    if (int'(dec_phase) + 1 < bpp) begin
      if (dec_phase == 0) dec_held = {8'h00, b};
      else dec_held = {b, dec_held[7:0]};
      dec_phase = dec_phase + 1'b1;
      return 1'b0;
    end
    v = {b, dec_held[7:0]};
    case (live_cfg.pixel_format)
      bpsr_pkg::FMT_BGR888: px.color = {b[7:3], dec_held[15:10], dec_held[7:3]};
      bpsr_pkg::FMT_RGB555: px.color = {v[14:5], 1'b0, v[4:0]};
      default:              px.color = v;
    endcase
    dec_phase = '0;
    dec_held  = '0;
    if (live_cfg.center_on_screen) begin
      // Signed halving truncates toward zero, so oversized images go negative.
      ox = 16'((ScreenW - int'(live_cfg.image_width)) / 2);
      oy = 16'((ScreenH - int'(live_cfg.image_height)) / 2);
    end else begin
      ox = live_cfg.origin_x;
      oy = live_cfg.origin_y;
    end
    px.x = ox + 16'(dec_col);
    px.y = oy + ((dec_rows > 0) ? 16'(dec_rows - 1'b1) : 16'd0);
    if (int'(dec_col) + 1 >= int'(live_cfg.image_width)) begin
      dec_col = '0;
      if (dec_rows <= 1) begin
        dec_rows = '0;
        dec_done = 1'b1;
        px.last  = 1'b1;
      end else begin
        pad = (4 - ((int'(live_cfg.image_width) * bpp) & 3)) & 3;
        if (pad != 0) dec_pad = 2'(pad);
        else close_row();
      end
    end else begin
      dec_col = dec_col + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic void apply_reg(input bpsr_pkg::cfg_idx_e idx, input logic [15:0] d);
    case (idx)
      bpsr_pkg::REG_IMAGE_WIDTH:   live_cfg.image_width      = d[10:0];
      bpsr_pkg::REG_IMAGE_HEIGHT:  live_cfg.image_height     = d[10:0];
      bpsr_pkg::REG_PIXEL_FORMAT:  live_cfg.pixel_format     = bpsr_pkg::pix_fmt_e'(d[1:0]);
      bpsr_pkg::REG_ORIGIN_X:      live_cfg.origin_x         = d;
      bpsr_pkg::REG_ORIGIN_Y:      live_cfg.origin_y         = d;
      bpsr_pkg::REG_CENTER:        live_cfg.center_on_screen = d[0];
      bpsr_pkg::REG_WINDOW_WIDTH:  live_cfg.window_width     = d;
      bpsr_pkg::REG_WINDOW_HEIGHT: live_cfg.window_height    = d;
      default: ;
    endcase
  endfunction

  task automatic put_reg(input bpsr_pkg::cfg_idx_e idx, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, d);
  endtask

  // Unused upper data bits are filled at random; the block must drop them.
  task automatic write_cfg(input bpsr_pkg::cfg_t c);
    put_reg(bpsr_pkg::REG_IMAGE_WIDTH, {5'($urandom), c.image_width});
    put_reg(bpsr_pkg::REG_IMAGE_HEIGHT, {5'($urandom), c.image_height});
    put_reg(bpsr_pkg::REG_PIXEL_FORMAT, {14'($urandom), c.pixel_format});
    put_reg(bpsr_pkg::REG_ORIGIN_X, c.origin_x);
    put_reg(bpsr_pkg::REG_ORIGIN_Y, c.origin_y);
    put_reg(bpsr_pkg::REG_CENTER, {15'($urandom), c.center_on_screen});
    put_reg(bpsr_pkg::REG_WINDOW_WIDTH, c.window_width);
    put_reg(bpsr_pkg::REG_WINDOW_HEIGHT, c.window_height);
    if ($urandom_range(0, 3) == 0) put_reg(RegUnused, 16'($urandom));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // Offers one byte, waits for it to be taken and records what it should give.
  task automatic push_byte(input logic [7:0] data, input logic fs, input bit typed,
                           input bit has_px, input pixel_t want);
    pixel_t got;
    bit     made;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= fs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    made = decode_byte(data, fs, got);
    bytes_sent++;
    if (typed) begin
      if (has_px) expected_pixels.push_back(want);
    end else if (made) begin
      expected_pixels.push_back(got);
    end
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Bytes that give no pixel may still sit in the pipe after the last word.
  task automatic wait_drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic bpsr_pkg::cfg_t make_cfg(input int w, input int h,
                                              input bpsr_pkg::pix_fmt_e f,
                                              input logic [15:0] ox, input logic [15:0] oy,
                                              input bit ctr, input logic [15:0] ww,
                                              input logic [15:0] wh);
    bpsr_pkg::cfg_t c;
    c.image_width      = 11'(w);
    c.image_height     = 11'(h);
    c.pixel_format     = f;
    c.origin_x         = ox;
    c.origin_y         = oy;
    c.center_on_screen = ctr;
    c.window_width     = ww;
    c.window_height    = wh;
    return c;
  endfunction

  function automatic void add_row(input int sel, input logic [7:0] d, input logic fs,
                                  input bit typed, input bit has_px, input logic [15:0] x,
                                  input logic [15:0] y, input logic [15:0] c,
                                  input logic last);
    stim_row_t r;
    r.sel    = sel;
    r.data   = d;
    r.fs     = fs;
    r.typed  = typed;
    r.has_px = has_px;
    r.px     = '{x: x, y: y, color: c, last: last};
    dir_rows.push_back(r);
  endfunction

  function automatic int pick_dim(input int mid_lo, input int mid_hi, input int norm_hi);
    int unsigned roll;
    roll = $urandom_range(0, 19);
    case (roll)
      0:       return 0;
      1:       return ($urandom_range(0, 2) == 0) ? 2047 : $urandom_range(1024, 1025);
      2:       return $urandom_range(mid_lo, mid_hi);
      3:       return $urandom_range(230, 700);
      default: return $urandom_range(1, norm_hi);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_window(input int dim);
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'($urandom);
      2:       return 16'(dim - 1);
      3:       return 16'(dim);
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic bpsr_pkg::cfg_t rand_cfg();
    int                 w;
    int                 h;
    bpsr_pkg::pix_fmt_e f;
    w = pick_dim(10, 40, 9);
    h = pick_dim(7, 30, 6);
    f = ($urandom_range(0, 9) == 0) ? bpsr_pkg::FMT_NONE :
        bpsr_pkg::pix_fmt_e'($urandom_range(1, 3));
    return make_cfg(w, h, f, pick_word(), pick_word(), $urandom_range(0, 2) == 0,
                    pick_window(w), pick_window(h));
  endfunction

  // Sends one image worth of bytes; large images and some others are cut short,
  // and some get trailing bytes or are replaced by noise with random starts.
  task automatic send_frame(input bit full_only);
    int bpp;
    int pad;
    int total;
    int n;
    int mode;
    bit noise;
    bpp   = (live_cfg.pixel_format == bpsr_pkg::FMT_BGR888) ? 3 : 2;
    pad   = (4 - ((int'(live_cfg.image_width) * bpp) & 3)) & 3;
    total = int'(live_cfg.image_height) * (int'(live_cfg.image_width) * bpp + pad) - pad;
    mode  = full_only ? 0 : $urandom_range(0, 9);
    noise = (mode == 8);
    if (!fits(live_cfg)) n = $urandom_range(1, 6);
    else if (noise) n = $urandom_range(1, 12);
    else if (mode == 6 || total > 300) n = $urandom_range(1, (total < 48) ? total : 48);
    else if (mode == 7) n = total + $urandom_range(1, 6);
    else n = total;
    for (int i = 0; i < n; i++)
      push_byte(8'($urandom), noise ? ($urandom_range(0, 5) == 0) : (i == 0), 1'b0, 1'b0,
                '0);
    frames_sent++;
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = bpsr_pkg::REG_IMAGE_WIDTH;
    cfg_data_i      = '0;
    live_cfg        = make_cfg(1, 1, bpsr_pkg::FMT_NONE, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0);

    dir_cfg[0] = make_cfg(2, 2, bpsr_pkg::FMT_RGB565, 16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF,
                          16'hFFFF);
    dir_cfg[1] = make_cfg(1, 3, bpsr_pkg::FMT_BGR888, 16'h1234, 16'h5678, 1'b1, 16'd1024,
                          16'd1024);
    dir_cfg[2] = make_cfg(1, 1, bpsr_pkg::FMT_RGB555, 16'h0000, 16'h0000, 1'b0, 16'd1,
                          16'd1);
    dir_cfg[3] = make_cfg(1025, 1, bpsr_pkg::FMT_RGB565, 16'h0000, 16'h0000, 1'b0,
                          16'hFFFF, 16'hFFFF);

    // Reset settings: a byte before any frame start, then an undrawable format.
    add_row(-1, 8'hA5, 1'b0, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h5A, 1'b1, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    // 2x2 RGB565 at the far corner: coordinates wrap around.
    add_row( 0, 8'h00, 1'b1, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 1, 1, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
    add_row(-1, 8'hFF, 1'b0, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'hFF, 1'b0, 1, 1, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    add_row(-1, 8'h34, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h12, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'hCD, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'hAB, 1'b0, 1, 1, 16'h0000, 16'hFFFF, 16'hABCD, 1'b1);
    add_row(-1, 8'h55, 1'b0, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    // 1x3 BGR888 centered: one pad byte per row, pure blue, green and red.
    add_row( 1, 8'hFF, 1'b1, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 1, 1, 16'd159, 16'd120, 16'h001F, 1'b0);
    add_row(-1, 8'h77, 1'b0, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'hFF, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 1, 1, 16'd159, 16'd119, 16'h07E0, 1'b0);
    add_row(-1, 8'h88, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'h00, 1'b0, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'hFF, 1'b0, 1, 1, 16'd159, 16'd118, 16'hF800, 1'b1);
    // 1x1 RGB555 in a window of exactly that size.
    add_row( 2, 8'hFF, 1'b1, 0, 0, 16'h0, 16'h0, 16'h0, 1'b0);
    add_row(-1, 8'hFF, 1'b0, 1, 1, 16'h0000, 16'h0000, 16'hFFDF, 1'b1);
    // One column wider than the largest supported image.
    add_row( 3, 8'h12, 1'b1, 1, 0, 16'h0, 16'h0, 16'h0, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].sel >= 0) begin
        wait_drain();
        write_cfg(dir_cfg[dir_rows[i].sel]);
      end
      push_byte(dir_rows[i].data, dir_rows[i].fs, dir_rows[i].typed, dir_rows[i].has_px,
                dir_rows[i].px);
    end
    wait_drain();

    // The receiver stops for a long stretch while a whole image is offered.
    write_cfg(make_cfg(8, 4, bpsr_pkg::FMT_RGB565, 16'd10, 16'd20, 1'b0, 16'hFFFF,
                       16'hFFFF));
    hold_req = 1'b1;
    send_frame(1'b1);
    wait_drain();

    while (decoded_bytes < DecodeTarget) begin
      if (decoded_bytes >= QuietAfter) quiet = 1'b1;
      write_cfg(rand_cfg());
      repeat ($urandom_range(1, 3)) send_frame(1'b0);
      wait_drain();
    end

    $display("Ran %0d bytes (%0d decoded) in %0d images over %0d header settings.",
             bytes_sent, decoded_bytes, frames_sent, settings_used);
    $display("Compared %0d pixels across all formats, padding, centering and window limits.",
             pixels_seen);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Output side: random stalls, one long hold on request, none near the end.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_pixels
    pixel_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch("unexpected word, color", m_axis_tdata_o[47:32], 16'h0);
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata_o[15:0] !== want.x)
          note_mismatch("pixel_x", m_axis_tdata_o[15:0], want.x);
        if (m_axis_tdata_o[31:16] !== want.y)
          note_mismatch("pixel_y", m_axis_tdata_o[31:16], want.y);
        if (m_axis_tdata_o[47:32] !== want.color)
          note_mismatch("color565", m_axis_tdata_o[47:32], want.color);
        if (m_axis_tlast_o !== want.last)
          note_mismatch("last_pixel", 16'(m_axis_tlast_o), 16'(want.last));
      end
      pixels_seen++;
    end
  end

endmodule

`default_nettype wire

>>> files.f
rtl/bpsr_pkg.sv
rtl/bpsr_cfg_regs.sv
rtl/bpsr_in_stage.sv
rtl/bpsr_decoder.sv
rtl/bpsr_out_reg.sv
rtl/bmp_pixel_stream_to_rgb565_unit.sv
tb/bmp_pixel_stream_to_rgb565_unit_test.sv
